@@ rtl/htp_pkg.sv @@
// Shared types and constants for the heater time-proportioning controller.
// No dependencies; imported by the stream interface users and the top level.
package htp_pkg;

  // Command codes carried by an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Lid event codes in a result item
  localparam logic [1:0] LID_NONE   = 2'd0;
  localparam logic [1:0] LID_CLOSED = 2'd1;
  localparam logic [1:0] LID_OPENED = 2'd2;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DUTY   = 2'd0;
  localparam logic [1:0] REG_COOK   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Field and state widths
  localparam int DUTY_W   = 4;
  localparam int MIN_W    = 11;
  localparam int PERIOD_W = 20;
  localparam int PHASE_W  = 20;
  localparam int MS_W     = 10;
  localparam int SEC_W    = 6;
  localparam int PROD_W   = 24;

  // Behavior constants
  localparam logic signed [11:0]   WARM_LIMIT     = 12'sd1920; // 120 C in 1/16 C
  localparam logic [DUTY_W-1:0]    DUTY_FULL      = 4'd10;
  localparam logic [DUTY_W-1:0]    DUTY_DEFAULT   = 4'd1;
  localparam logic [MIN_W-1:0]     MAX_MINUTES    = 11'd1440;
  localparam logic [PERIOD_W-1:0]  PERIOD_DEFAULT = 20'd60000;
  localparam logic [MS_W-1:0]      MS_LAST        = 10'd999;
  localparam logic [SEC_W-1:0]     SEC_LAST       = 6'd59;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [11:0] temperature;
    logic               lid_open;
  } cmd_t;

  typedef struct packed {
    logic             heater_on;
    logic [1:0]       lid_event;
    logic             cook_ended;
    logic             cooking;
    logic             warming;
    logic [MIN_W-1:0] minutes_left;
  } res_t;

endpackage

@@ rtl/htp_stream_if.sv @@
// Valid/ready stream interface with a typed payload.
// Used for both the command and the result channel; payload types from htp_pkg.
interface htp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/heater_time_proportion_controller_top.sv @@
// Heater time-proportioning relay controller, top level.
// Depends on htp_pkg and htp_stream_if.
//
// Takes one command per clock (tick, start, stop) while results are taken, and returns one
// status result per command. An accepted command sits in an input register, is evaluated
// against the controller state in a single pass, and its result lands in the output
// register. A stalled result holds the next command in the input register, and further
// input transfers stop once it is full. On/off timing compares 10*(elapsed+1) against
// duty*period products, so no divider is needed. The APB-style port is to be written only
// while no command is in flight.
module heater_time_proportion_controller_top
  import htp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  htp_stream_if.sink            in_ch,
  htp_stream_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Pipeline registers
  logic in_vld_r;
  cmd_t in_cmd_r;
  logic out_vld_r;
  res_t out_res_r;
  logic adv;
  logic fire;

  // Configuration registers
  logic [DUTY_W-1:0]   duty_r,     duty_nxt;
  logic [MIN_W-1:0]    cook_min_r, cook_min_nxt;
  logic [PERIOD_W-1:0] period_r;

  // Controller state
  logic               cooking_r, cooking_nxt;
  logic               warm_r,    warm_nxt;
  logic               heater_r,  heater_nxt;
  logic               lid_prev_r, lid_prev_nxt;
  logic [PHASE_W-1:0] phase_r,   phase_nxt;
  logic [MS_W-1:0]    ms_r,      ms_nxt;
  logic [SEC_W-1:0]   sec_r,     sec_nxt;
  logic [MIN_W-1:0]   min_el_r,  min_el_nxt;

  // Datapath
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W:0]   phase_plus;
  logic [PROD_W-1:0]  phase_scaled;
  logic [PROD_W-1:0]  on_prod;
  logic [PROD_W-1:0]  off_prod;
  logic               want;
  logic               ended;
  logic [1:0]         lid_evt;
  logic [MIN_W-1:0]   mins_left;
  res_t               res_nxt;

  // Configuration access
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic [DUTY_W-1:0]    wr_duty;
  logic [MIN_W-1:0]     wr_cook;

  // Handshake: output register frees when empty or taken
  assign adv          = !out_vld_r || out_ch.ready;
  assign fire         = adv && in_vld_r;
  assign in_ch.ready  = !in_vld_r || adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  // Relay timing: elapsed < floor(x/10)  <=>  10*(elapsed+1) <= x
  assign phase_inc    = (phase_r == '1) ? phase_r : phase_r + 1'b1;
  assign phase_plus   = {1'b0, phase_inc} + 1'b1;
  assign phase_scaled = {2'b00, phase_plus, 1'b0} + {phase_plus, 3'b000};
  assign on_prod      = PROD_W'(duty_r) * PROD_W'(period_r);
  assign off_prod     = PROD_W'(DUTY_FULL - duty_r) * PROD_W'(period_r);

  // Next state for one command
  always_comb begin
    duty_nxt     = duty_r;
    cook_min_nxt = cook_min_r;
    cooking_nxt  = cooking_r;
    warm_nxt     = warm_r;
    heater_nxt   = heater_r;
    lid_prev_nxt = lid_prev_r;
    phase_nxt    = phase_r;
    ms_nxt       = ms_r;
    sec_nxt      = sec_r;
    min_el_nxt   = min_el_r;
    want         = 1'b0;
    ended        = 1'b0;
    lid_evt      = LID_NONE;
    unique case (in_cmd_r.command)
      CMD_TICK: begin
        lid_prev_nxt = in_cmd_r.lid_open;
        if (cooking_r) begin
          // relay decision
          if (warm_r) begin
            if (in_cmd_r.temperature <= WARM_LIMIT) begin
              want = 1'b1;
            end else begin
              want     = 1'b0;
              warm_nxt = 1'b0;
            end
          end else if (heater_r) begin
            want = phase_scaled <= on_prod;
          end else begin
            want = !(phase_scaled <= off_prod);
          end
          phase_nxt  = (want != heater_r) ? '0 : phase_inc;
          heater_nxt = want;
          // cook timer, ms -> s -> min
          if (ms_r == MS_LAST) begin
            ms_nxt = '0;
            if (sec_r == SEC_LAST) begin
              sec_nxt = '0;
              if (min_el_r != '1) begin
                min_el_nxt = min_el_r + 1'b1;
              end
            end else begin
              sec_nxt = sec_r + 1'b1;
            end
          end else begin
            ms_nxt = ms_r + 1'b1;
          end
          // cook time ran out
          if (cook_min_r != '0 && min_el_nxt >= cook_min_r) begin
            ended        = 1'b1;
            cooking_nxt  = 1'b0;
            warm_nxt     = 1'b0;
            heater_nxt   = 1'b0;
            duty_nxt     = DUTY_DEFAULT;
            cook_min_nxt = '0;
          end
          // lid edges
          if (lid_prev_r && !in_cmd_r.lid_open) begin
            lid_evt = LID_CLOSED;
          end else if (!lid_prev_r && in_cmd_r.lid_open) begin
            lid_evt = LID_OPENED;
          end
        end
      end
      CMD_START: begin
        cooking_nxt = 1'b1;
        warm_nxt    = 1'b1;
        ms_nxt      = '0;
        sec_nxt     = '0;
        min_el_nxt  = '0;
      end
      CMD_STOP: begin
        cooking_nxt  = 1'b0;
        warm_nxt     = 1'b0;
        heater_nxt   = 1'b0;
        duty_nxt     = DUTY_DEFAULT;
        cook_min_nxt = '0;
      end
      default: begin
      end
    endcase

    // remaining whole minutes: M - elapsed_min - (partial minute ? 1 : 0)
    if (cook_min_nxt == '0 || min_el_nxt >= cook_min_nxt) begin
      mins_left = '0;
    end else begin
      mins_left = cook_min_nxt - min_el_nxt - MIN_W'(sec_nxt != '0);
    end

    res_nxt.heater_on    = heater_nxt;
    res_nxt.lid_event    = lid_evt;
    res_nxt.cook_ended   = ended;
    res_nxt.cooking      = cooking_nxt;
    res_nxt.warming      = warm_nxt;
    res_nxt.minutes_left = mins_left;
  end

  // Configuration decode
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_duty = (pwdata[DUTY_W-1:0] > DUTY_FULL) ? DUTY_FULL : pwdata[DUTY_W-1:0];
  assign wr_cook = pwdata[MIN_W-1:0];

  always_comb begin
    unique case (cfg_idx)
      REG_DUTY:   prdata = CFG_DATA_W'(duty_r);
      REG_COOK:   prdata = CFG_DATA_W'(cook_min_r);
      REG_PERIOD: prdata = CFG_DATA_W'(period_r);
      default:    prdata = '0;
    endcase
  end

  // State and configuration registers; the user must write only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= DUTY_DEFAULT;
      cook_min_r <= '0;
      period_r   <= PERIOD_DEFAULT;
      cooking_r  <= 1'b0;
      warm_r     <= 1'b0;
      heater_r   <= 1'b0;
      lid_prev_r <= 1'b0;
      phase_r    <= '0;
      ms_r       <= '0;
      sec_r      <= '0;
      min_el_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DUTY: begin
          duty_r <= wr_duty;
        end
        REG_COOK: begin
          if (wr_cook <= MAX_MINUTES) begin
            cook_min_r <= wr_cook;
            ms_r       <= '0;
            sec_r      <= '0;
            min_el_r   <= '0;
          end
        end
        REG_PERIOD: begin
          period_r <= pwdata[PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (fire) begin
      duty_r     <= duty_nxt;
      cook_min_r <= cook_min_nxt;
      cooking_r  <= cooking_nxt;
      warm_r     <= warm_nxt;
      heater_r   <= heater_nxt;
      lid_prev_r <= lid_prev_nxt;
      phase_r    <= phase_nxt;
      ms_r       <= ms_nxt;
      sec_r      <= sec_nxt;
      min_el_r   <= min_el_nxt;
    end
  end

  // Checks
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cooking_r |-> !heater_r && !warm_r)
    else $error("heater or warm-up active while not cooking");

  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    ms_r <= MS_LAST && sec_r <= SEC_LAST)
    else $error("cook timer digit out of range");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.cook_ended |->
      !out_res_r.cooking && !out_res_r.heater_on && out_res_r.minutes_left == '0)
    else $error("cook end result still shows activity");

  a_cook_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cook_min_r <= MAX_MINUTES && duty_r <= DUTY_FULL)
    else $error("configuration register beyond limit");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_res_r))
    else $error("stalled result changed");

endmodule
